/* hdl/ieval_pkg.sv */
// ----------------------------------------------------------------------------
// ieval_pkg: shared types and constants of the infix expression evaluator
// Operator codes, status codes, character constants, sequencer states and
// the request/response structs of the shared arithmetic unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ieval_pkg;

   // Operator codes as kept on the operator stack
   typedef enum logic [2:0] {
      OP_ADD    = 3'd0,
      OP_SUB    = 3'd1,
      OP_MUL    = 3'd2,
      OP_DIV    = 3'd3,
      OP_LPAREN = 3'd4
   } op_code_type;

   // Result status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_DIV_ZERO  = 3'd1;
   localparam logic [2:0] ST_MALFORMED = 3'd2;
   localparam logic [2:0] ST_BAD_CHAR  = 3'd3;
   localparam logic [2:0] ST_OVERFLOW  = 3'd4;

   // Characters
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_TAB    = 8'd9;
   localparam logic [7:0] CHAR_CR     = 8'd13;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;

   // Sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_FINNUM,
      S_DISPATCH,
      S_LOOP,
      S_CHECK,
      S_RDB,
      S_RDA,
      S_EXEC,
      S_WAIT,
      S_OUTPUT,
      S_RESULT
   } state_type;

   // What ends the current reduction loop
   typedef enum logic [1:0] {
      M_ADD,
      M_MUL,
      M_CLOSE,
      M_END
   } mode_type;

   typedef struct packed {
      logic        start;
      op_code_type op;
   } alu_req_type;

   typedef struct packed {
      logic done;
      logic div_zero;
   } alu_rsp_type;

endpackage

`default_nettype wire

/* hdl/ieval_ram.sv */
// ----------------------------------------------------------------------------
// ieval_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ieval_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* hdl/ieval_alu.sv */
// ----------------------------------------------------------------------------
// ieval_alu: shared arithmetic unit
// Add, subtract and multiply with a registered result; signed division one quotient
// bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ieval_alu
   import ieval_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire alu_req_type req,
   input  wire logic [31:0] a,
   input  wire logic [31:0] b,
   output alu_rsp_type      rsp,
   output logic      [31:0] result
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        dz_ff, dz_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] mb_ff, mb_in;
   logic        neg_ff, neg_in;
   logic [31:0] res_ff, res_in;

   logic [32:0] rem_shift;
   logic [32:0] rem_diff;
   logic [31:0] quo_next;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      dz_in   = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      mb_in   = mb_ff;
      neg_in  = neg_ff;
      res_in  = res_ff;

      // one restoring step
      rem_shift = {rem_ff, quo_ff[31]};
      rem_diff  = rem_shift - {1'b0, mb_ff};
      quo_next  = {quo_ff[30:0], ~rem_diff[32]};

      if (busy_ff) begin
         rem_in = rem_diff[32] ? rem_shift[31:0] : rem_diff[31:0];
         quo_in = quo_next;
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = neg_ff ? (~quo_next + 32'd1) : quo_next;
         end
      end else if (req.start) begin
         unique case (req.op)
            OP_ADD: begin
               res_in  = a + b;
               done_in = 1'b1;
            end
            OP_SUB: begin
               res_in  = a - b;
               done_in = 1'b1;
            end
            OP_MUL: begin
               res_in  = a * b;
               done_in = 1'b1;
            end
            OP_DIV: begin
               if (b == 32'd0) begin
                  dz_in   = 1'b1;
                  done_in = 1'b1;
               end else begin
                  busy_in = 1'b1;
                  cnt_in  = 5'd31;
                  rem_in  = 32'd0;
                  quo_in  = a[31] ? (~a + 32'd1) : a;
                  mb_in   = b[31] ? (~b + 32'd1) : b;
                  neg_in  = a[31] ^ b[31];
               end
            end
            default: begin
               res_in  = 32'd0;
               done_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         dz_ff   <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         dz_ff   <= dz_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      mb_ff  <= mb_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.div_zero = dz_ff;
   assign result       = res_ff;

endmodule

`default_nettype wire

/* hdl/infix_expression_evaluator_unit.sv */
// ----------------------------------------------------------------------------
// infix_expression_evaluator_unit: two-stack integer infix evaluator
// Reads an expression one ASCII byte per word, closes it with tlast, and
// returns the 32-bit wrapped result with a status code.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                              | tlast
//  req_    | in  | [7:0] char_in                      | end_of_text
//  rsp_    | out | [31:0] value, [34:32] status, pad  | -
//
//  A digit, or a byte ignored after an error, is taken in the idle state.
//  Whitespace, '(' and a bad character pass through the number-close and
//  dispatch states; an operator or ')' also passes through the operator check
//  and then one reduction per pending operator it pops. A division reduction
//  takes longer, as the shared arithmetic unit's divider is bit-serial. The end
//  word also reads the final result from the stack. Reset is synchronous and
//  clears all control state; stack contents need none. A result stalled on
//  rsp_tready holds the sequencer, and req_tready stays low until it returns to idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module infix_expression_evaluator_unit
   import ieval_pkg::*;
#(
   parameter int VALUE_DEPTH    = 32,
   parameter int OPERATOR_DEPTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_in
   input  wire logic        req_tlast,   // end_of_text
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [39:0] rsp_tdata    // [31:0] value, [34:32] status, rest zero
);

   localparam int VAW = $clog2(VALUE_DEPTH);
   localparam int VCW = $clog2(VALUE_DEPTH + 1);
   localparam int OAW = $clog2(OPERATOR_DEPTH);
   localparam int OCW = $clog2(OPERATOR_DEPTH + 1);

   // keep the first error only
   function automatic logic [2:0] first_err(logic [2:0] cur, logic [2:0] code);
      return (cur == ST_OK) ? code : cur;
   endfunction

   state_type   state_ff, state_in;
   mode_type    mode_ff, mode_in;
   op_code_type pend_op_ff, pend_op_in;
   op_code_type red_op_ff, red_op_in;
   logic [7:0]  char_ff, char_in;
   logic        end_ff, end_in;
   logic [VCW-1:0] vcnt_ff, vcnt_in;
   logic [OCW-1:0] ocnt_ff, ocnt_in;
   logic [31:0] acc_ff, acc_in;
   logic        in_num_ff, in_num_in;
   logic        seen_ff, seen_in;
   logic [2:0]  err_ff, err_in;
   logic [31:0] b_ff, b_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_value_ff, rsp_value_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;

   // stack ports
   logic           v_wr_en;
   logic [VAW-1:0] v_wr_addr, v_rd_addr;
   logic [31:0]    v_wr_data, v_rd_data;
   logic           o_wr_en;
   logic [OAW-1:0] o_wr_addr;
   logic [2:0]     o_wr_data, o_rd_data;

   logic [VCW-1:0] vcnt_m1, vcnt_m2;
   logic [OCW-1:0] ocnt_m1;

   alu_req_type alu_req;
   alu_rsp_type alu_rsp;
   logic [31:0] alu_result;

   logic [7:0]  digit;
   logic        is_digit, is_space;
   op_code_type top_op;
   logic        have_op, top_arith, top_mul, go;

   assign vcnt_m1 = vcnt_ff - VCW'(1);
   assign vcnt_m2 = vcnt_ff - VCW'(2);
   assign ocnt_m1 = ocnt_ff - OCW'(1);
   assign digit   = req_tdata - CHAR_ZERO;
   assign is_digit = (req_tdata >= CHAR_ZERO) && (req_tdata <= CHAR_NINE);
   assign is_space = (char_ff == CHAR_SPACE) || ((char_ff >= CHAR_TAB) && (char_ff <= CHAR_CR));
   assign top_op    = op_code_type'(o_rd_data);
   assign have_op   = (ocnt_ff != '0);
   assign top_arith = have_op && (top_op != OP_LPAREN);
   assign top_mul   = have_op && ((top_op == OP_MUL) || (top_op == OP_DIV));

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      pend_op_in    = pend_op_ff;
      red_op_in     = red_op_ff;
      char_in       = char_ff;
      end_in        = end_ff;
      vcnt_in       = vcnt_ff;
      ocnt_in       = ocnt_ff;
      acc_in        = acc_ff;
      in_num_in     = in_num_ff;
      seen_in       = seen_ff;
      err_in        = err_ff;
      b_in          = b_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      v_wr_en   = 1'b0;
      v_wr_addr = vcnt_ff[VAW-1:0];
      v_wr_data = acc_ff;
      v_rd_addr = vcnt_m1[VAW-1:0];
      o_wr_en   = 1'b0;
      o_wr_addr = ocnt_ff[OAW-1:0];
      o_wr_data = pend_op_ff;
      alu_req.start = 1'b0;
      alu_req.op    = red_op_ff;
      go = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               char_in = req_tdata;
               end_in  = req_tlast;
               priority if (req_tlast) begin
                  state_in = S_FINNUM;
               end else if (err_ff != ST_OK) begin
                  // drop bytes after an error
               end else if (is_digit) begin
                  priority if (in_num_ff) begin
                     acc_in = {acc_ff[28:0], 3'b000} + {acc_ff[30:0], 1'b0}
                              + {24'd0, digit};
                  end else if (seen_ff) begin
                     err_in = ST_MALFORMED;
                  end else begin
                     acc_in    = {24'd0, digit};
                     in_num_in = 1'b1;
                     seen_in   = 1'b1;
                  end
               end else begin
                  state_in = S_FINNUM;
               end
            end
         end
         S_FINNUM: begin
            // close a pending number onto the value stack
            if (in_num_ff && err_ff == ST_OK) begin
               in_num_in = 1'b0;
               acc_in    = 32'd0;
               if (vcnt_ff == VCW'(VALUE_DEPTH)) begin
                  err_in = ST_OVERFLOW;
               end else begin
                  v_wr_en = 1'b1;
                  vcnt_in = vcnt_ff + VCW'(1);
               end
            end
            state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            priority if (err_ff != ST_OK) begin
               state_in = end_ff ? S_OUTPUT : S_IDLE;
            end else if (end_ff) begin
               if (!seen_ff) begin
                  err_in   = ST_MALFORMED;
                  state_in = S_OUTPUT;
               end else begin
                  mode_in  = M_END;
                  state_in = S_LOOP;
               end
            end else if (is_space) begin
               state_in = S_IDLE;
            end else if (char_ff == CHAR_PLUS || char_ff == CHAR_MINUS
                         || char_ff == CHAR_STAR || char_ff == CHAR_SLASH) begin
               if (!seen_ff) begin
                  err_in   = ST_MALFORMED;
                  state_in = S_IDLE;
               end else begin
                  priority if (char_ff == CHAR_PLUS) pend_op_in = OP_ADD;
                  else if (char_ff == CHAR_MINUS) pend_op_in = OP_SUB;
                  else if (char_ff == CHAR_STAR) pend_op_in = OP_MUL;
                  else pend_op_in = OP_DIV;
                  mode_in  = (char_ff == CHAR_STAR || char_ff == CHAR_SLASH) ? M_MUL : M_ADD;
                  seen_in  = 1'b0;
                  state_in = S_LOOP;
               end
            end else if (char_ff == CHAR_LPAREN) begin
               state_in = S_IDLE;
               if (seen_ff) begin
                  err_in = ST_MALFORMED;
               end else if (ocnt_ff == OCW'(OPERATOR_DEPTH)) begin
                  err_in = ST_OVERFLOW;
               end else begin
                  o_wr_en   = 1'b1;
                  o_wr_data = OP_LPAREN;
                  ocnt_in   = ocnt_ff + OCW'(1);
               end
            end else if (char_ff == CHAR_RPAREN) begin
               if (!seen_ff) begin
                  err_in   = ST_MALFORMED;
                  state_in = S_IDLE;
               end else begin
                  mode_in  = M_CLOSE;
                  state_in = S_LOOP;
               end
            end else begin
               err_in   = ST_BAD_CHAR;
               state_in = S_IDLE;
            end
         end
         S_LOOP: begin
            // operator top is read here, examined next cycle
            if (err_ff != ST_OK) begin
               state_in = (mode_ff == M_END) ? S_OUTPUT : S_IDLE;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            unique case (mode_ff)
               M_MUL:   go = top_mul;
               M_ADD:   go = top_arith;
               M_CLOSE: go = top_arith;
               M_END:   go = have_op;
               default: go = 1'b0;
            endcase
            priority if (mode_ff == M_END && have_op && top_op == OP_LPAREN) begin
               err_in   = ST_MALFORMED;
               state_in = S_OUTPUT;
            end else if (go) begin
               red_op_in = top_op;
               state_in  = S_RDB;
            end else begin
               unique case (mode_ff)
                  M_MUL, M_ADD: begin
                     state_in = S_IDLE;
                     if (ocnt_ff == OCW'(OPERATOR_DEPTH)) begin
                        err_in = ST_OVERFLOW;
                     end else begin
                        o_wr_en = 1'b1;
                        ocnt_in = ocnt_ff + OCW'(1);
                     end
                  end
                  M_CLOSE: begin
                     state_in = S_IDLE;
                     if (!have_op) begin
                        err_in = ST_MALFORMED;
                     end else begin
                        ocnt_in = ocnt_m1;
                     end
                  end
                  default: begin
                     state_in = S_OUTPUT;
                     if (vcnt_ff != VCW'(1)) begin
                        err_in = ST_MALFORMED;
                     end
                  end
               endcase
            end
         end
         S_RDB: begin
            if (vcnt_ff < VCW'(2)) begin
               err_in   = ST_MALFORMED;
               state_in = S_LOOP;
            end else begin
               state_in = S_RDA;
            end
         end
         S_RDA: begin
            v_rd_addr = vcnt_m2[VAW-1:0];
            b_in      = v_rd_data;
            state_in  = S_EXEC;
         end
         S_EXEC: begin
            v_rd_addr     = vcnt_m2[VAW-1:0];
            alu_req.start = 1'b1;
            state_in      = S_WAIT;
         end
         S_WAIT: begin
            if (alu_rsp.done) begin
               state_in = S_LOOP;
               if (alu_rsp.div_zero) begin
                  err_in = first_err(err_ff, ST_DIV_ZERO);
               end else begin
                  v_wr_en   = 1'b1;
                  v_wr_addr = vcnt_m2[VAW-1:0];
                  v_wr_data = alu_result;
                  vcnt_in   = vcnt_m1;
                  ocnt_in   = ocnt_m1;
               end
            end
         end
         S_OUTPUT: begin
            v_rd_addr = '0;
            state_in  = S_RESULT;
         end
         S_RESULT: begin
            v_rd_addr = '0;
            // hold until the output register is free, then clear for next text
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = (err_ff == ST_OK) ? v_rd_data : 32'd0;
               rsp_status_in = err_ff;
               vcnt_in   = '0;
               ocnt_in   = '0;
               acc_in    = 32'd0;
               in_num_in = 1'b0;
               seen_in   = 1'b0;
               err_in    = ST_OK;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vcnt_ff      <= '0;
         ocnt_ff      <= '0;
         acc_ff       <= 32'd0;
         in_num_ff    <= 1'b0;
         seen_ff      <= 1'b0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= M_ADD;
         end_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcnt_ff      <= vcnt_in;
         ocnt_ff      <= ocnt_in;
         acc_ff       <= acc_in;
         in_num_ff    <= in_num_in;
         seen_ff      <= seen_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         end_ff       <= end_in;
      end
      pend_op_ff    <= pend_op_in;
      red_op_ff     <= red_op_in;
      char_ff       <= char_in;
      b_ff          <= b_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   ieval_ram #(.WIDTH(32), .DEPTH(VALUE_DEPTH)) u_value_stack (
      .clock   (clock),
      .wr_en   (v_wr_en),
      .wr_addr (v_wr_addr),
      .wr_data (v_wr_data),
      .rd_addr (v_rd_addr),
      .rd_data (v_rd_data)
   );

   ieval_ram #(.WIDTH(3), .DEPTH(OPERATOR_DEPTH)) u_operator_stack (
      .clock   (clock),
      .wr_en   (o_wr_en),
      .wr_addr (o_wr_addr),
      .wr_data (o_wr_data),
      .rd_addr (ocnt_m1[OAW-1:0]),
      .rd_data (o_rd_data)
   );

   ieval_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .req    (alu_req),
      .a      (v_rd_data),
      .b      (b_ff),
      .rsp    (alu_rsp),
      .result (alu_result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_status_ff, rsp_value_ff};

`ifndef SYNTHESIS
   // stack fill never passes the depth
   a_vcnt_bound: assert property (@(posedge clock) disable iff (reset)
      vcnt_ff <= VCW'(VALUE_DEPTH))
      else $error("value stack count beyond depth");

   a_ocnt_bound: assert property (@(posedge clock) disable iff (reset)
      ocnt_ff <= OCW'(OPERATOR_DEPTH))
      else $error("operator stack count beyond depth");

   // handing over a result leaves a clean evaluator and a pending word
   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESULT && state_in == S_IDLE) |=>
         (vcnt_ff == '0 && ocnt_ff == '0 && err_ff == ST_OK && rsp_valid_ff))
      else $error("evaluator not cleared after result");
`endif

endmodule

`default_nettype wire
